@@ rtl/assert_macros.svh @@
// assertion macros shared by the tokenizer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/cst_pkg.sv @@
// types, codes and constants of the csv stream tokenizer
// no dependencies; imported by cst_core, cst_fifo and csv_stream_tokenizer
package cst_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SP = 8'd32;

  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;
  localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 8'd1;

  typedef enum logic [2:0] {
    ST_LEAD   = 3'd0,
    ST_OUT    = 3'd1,
    ST_INQ    = 3'd2,
    ST_QOPEN  = 3'd3,
    ST_QCLOSE = 3'd4
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_APPEND    = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2,
    KIND_INVALID   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] field_byte;
    logic [BYTE_W-1:0] trim_count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic result_t mk_result(kind_e kind, logic [BYTE_W-1:0] field_byte,
                                        logic [BYTE_W-1:0] trim_count);
    result_t r;
    r.kind       = kind;
    r.field_byte = field_byte;
    r.trim_count = trim_count;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/cst_core.sv @@
// input register, config registers, quote state machine and per-byte step logic
// depends on cst_pkg and assert_macros.svh
`include "assert_macros.svh"

module cst_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cst_pkg::BYTE_W-1:0]    in_byte_i,
  input  logic                          finish_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cst_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cst_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                          space_ok_i,
  output logic                          step_valid_o,
  output cst_pkg::step_t                step_o
);
  import cst_pkg::*;

  logic              in_vld_q;
  logic [BYTE_W-1:0] byte_q;
  logic              fin_q;
  logic              fire;

  logic [BYTE_W-1:0] delim_q, quote_q;

  parse_state_e      st_q, st_d, mid_st;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic [BYTE_W-1:0] ts_q, ts_d, ts_mid;
  logic              fo_q, fo_d;
  logic              le, go;
  step_t             step;

  assign fire         = in_vld_q && space_ok_i;
  assign in_ready_o   = !in_vld_q || fire;
  assign step_valid_o = fire;
  assign step_o       = step;
  assign cfg_ready_o  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      fin_q  <= finish_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
      quote_q <= QUOTE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DELIMITER: delim_q <= cfg_data_i;
        CFG_QUOTE:     quote_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_LEAD;
      prev_q <= '0;
      ts_q   <= '0;
      fo_q   <= 1'b0;
    end else if (fire) begin
      st_q   <= st_d;
      prev_q <= prev_d;
      ts_q   <= ts_d;
      fo_q   <= fo_d;
    end
  end

  assign le = (byte_q == CH_LF) || (byte_q == CH_CR);

  always_comb begin
    st_d       = st_q;
    prev_d     = prev_q;
    ts_d       = ts_q;
    fo_d       = fo_q;
    mid_st     = st_q;
    ts_mid     = ts_q;
    go         = 1'b0;
    step.count = 2'd0;
    step.r0    = mk_result(KIND_APPEND, '0, '0);
    step.r1    = mk_result(KIND_APPEND, '0, '0);

    if (fin_q) begin
      if (st_q == ST_INQ) begin
        step.count = 2'd1;
        step.r0    = mk_result(KIND_INVALID, '0, '0);
      end else begin
        if (fo_q) begin
          step.count = 2'd2;
          step.r0    = mk_result(KIND_FIELD_END, '0, ts_q);
          step.r1    = mk_result(KIND_ROW_END, '0, '0);
        end
        st_d   = ST_LEAD;
        prev_d = '0;
        ts_d   = '0;
        fo_d   = 1'b0;
      end
    end else if (le && st_q != ST_INQ && byte_q != prev_q &&
                 (prev_q == CH_LF || prev_q == CH_CR)) begin
      // second half of a line end pair
      prev_d = '0;
    end else begin
      prev_d = byte_q;
      go     = 1'b1;
      unique case (st_q)
        ST_LEAD: begin
          fo_d = 1'b1;
          if (byte_q == CH_SP) begin
            go = 1'b0;
          end else begin
            mid_st = ST_OUT;
          end
        end
        ST_QOPEN: begin
          if (byte_q == quote_q && fo_q) begin
            step.count = 2'd1;
            step.r0    = mk_result(KIND_APPEND, quote_q, '0);
            st_d       = ST_OUT;
            go         = 1'b0;
          end else begin
            mid_st = ST_INQ;
          end
        end
        ST_QCLOSE: begin
          if (byte_q == quote_q) begin
            step.count = 2'd1;
            step.r0    = mk_result(KIND_APPEND, quote_q, '0);
            st_d       = ST_INQ;
            go         = 1'b0;
          end else begin
            mid_st = ST_OUT;
          end
        end
        default: ;
      endcase

      if (go) begin
        st_d = mid_st;
        unique case (mid_st)
          ST_OUT: begin
            if (le || byte_q == delim_q) begin
              st_d       = ST_LEAD;
              step.count = 2'd1;
              step.r0    = mk_result(KIND_FIELD_END, '0, ts_q);
              ts_mid     = '0;
              fo_d       = 1'b1;
            end else if (byte_q == quote_q) begin
              st_d = ST_QOPEN;
            end else begin
              step.count = 2'd1;
              step.r0    = mk_result(KIND_APPEND, byte_q, '0);
            end
            if (byte_q == CH_SP) begin
              ts_d = (ts_mid == '1) ? ts_mid : ts_mid + 8'd1;
            end else begin
              ts_d = '0;
            end
            if (le) begin
              fo_d       = 1'b0;
              step.count = 2'd2;
              step.r1    = mk_result(KIND_ROW_END, '0, '0);
            end
          end
          ST_INQ: begin
            if (byte_q == quote_q) begin
              st_d = ST_QCLOSE;
            end else begin
              step.count = 2'd1;
              step.r0    = mk_result(KIND_APPEND, byte_q, '0);
            end
          end
          default: ;
        endcase
      end
    end

    if (step.count == 2'd1) begin
      step.r0.last = 1'b1;
    end else if (step.count == 2'd2) begin
      step.r1.last = 1'b1;
    end
  end

  `ASSERT_ON(a_finish_clears, fire && fin_q && st_q != ST_INQ |=> st_q == ST_LEAD && !fo_q && ts_q == '0, "finish did not clear the parser state")
  `ASSERT_ON(a_pair_last, step.count == 2'd2 |-> !step.r0.last && step.r1.last, "last flag misplaced in a result pair")
  `ASSERT_ON(a_invalid_alone, step.r0.kind == KIND_INVALID |-> step.count == 2'd1 && fin_q, "invalid result outside a lone finish")

endmodule

@@ rtl/cst_fifo.sv @@
// result queue: takes up to two results per cycle, hands out one per transaction
// depends on cst_pkg and assert_macros.svh
`include "assert_macros.svh"

module cst_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  cst_pkg::step_t             step_i,
  output logic                       space_ok_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cst_pkg::result_t           result_o
);
  import cst_pkg::*;

  result_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_q, cnt_d, push_n;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign space_ok_o  = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
  assign result_o    = mem_q[rd_ptr_q];
  assign push_n      = push_i ? CNT_W'(step_i.count) : '0;
  assign wr_ptr_nxt  = wr_ptr_q + PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_n);
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + push_n - (pop ? CNT_W'(1) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && step_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= step_i.r0;
    end
    if (push_i && step_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= step_i.r1;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, !rst_ni || cnt_q <= CNT_W'(FIFO_DEPTH), "result queue overfilled")
  `ASSERT_ON(a_push_space,
             push_i && step_i.count != 2'd0 |-> space_ok_o,
             "push into a full queue")

endmodule

@@ rtl/csv_stream_tokenizer.sv @@
// top level of the csv stream tokenizer: step logic feeding a result queue
// depends on cst_pkg, cst_core and cst_fifo
//
//  channel  signals                                       dir
//  in       in_valid_i/in_ready_o, in_byte_i, finish_i     sink
//  cfg      cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i  sink
//  out      out_valid_o/out_ready_i, kind_o, field_byte_o,
//           trim_count_o, last_o                          source
//
// one byte per cycle is taken while the queue has space; a transaction passes the
// input register, the step logic and the four-entry result queue, so its first result
// is valid once the step logic has written it from the input register into the queue
// a row end or finish adds a second result, so the output sets the rate to one result
// per cycle with out_ready_i high; bytes are taken while at most two entries are held
// reset clears the parser state, the queue and restores delimiter and quote byte
// cfg writes are always ready and take effect at the next edge
module csv_stream_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cst_pkg::BYTE_W-1:0]    in_byte_i,
  input  logic                          finish_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cst_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cst_pkg::BYTE_W-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [cst_pkg::BYTE_W-1:0]    field_byte_o,
  output logic [cst_pkg::BYTE_W-1:0]    trim_count_o,
  output logic                          last_o
);
  import cst_pkg::*;

  logic    space_ok;
  logic    step_valid;
  step_t   step;
  result_t result;

  cst_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .finish_i     (finish_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .space_ok_i   (space_ok),
    .step_valid_o (step_valid),
    .step_o       (step)
  );

  cst_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step_valid),
    .step_i      (step),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign kind_o       = 2'(result.kind);
  assign field_byte_o = result.field_byte;
  assign trim_count_o = result.trim_count;
  assign last_o       = result.last;

endmodule
